### rtl/core/sbce_pkg.sv
// package for the serial bootloader command engine
// holds parse states, result kinds, sizes, CSR indices and result structs; no dependencies
`default_nettype none
package sbce_pkg;
   localparam int BufferBytes    = 128;
   localparam int FlashPageBytes = 128;
   localparam int BufWords       = BufferBytes / 2;
   localparam int PageWordsN     = FlashPageBytes / 2;
   localparam int FillWords      = (PageWordsN < BufWords) ? PageWordsN : BufWords;
   localparam int BufAw          = (BufWords > 1) ? $clog2(BufWords) : 1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_A_HI, ST_A_LO, ST_SKIP, ST_ERASE_ACK,
      ST_B_CHI, ST_B_CLO, ST_B_TYPE, ST_B_WHI, ST_B_WLO, ST_B_FILL_ACK, ST_B_WR_ACK,
      ST_B_EDATA, ST_B_EACK,
      ST_G_CHI, ST_G_CLO, ST_G_TYPE, ST_G_FACK, ST_G_EACK
   } parse_state_type;

   typedef enum logic [2:0] {
      KIND_TX, KIND_ERASE, KIND_FILL, KIND_PWRITE,
      KIND_EWRITE, KIND_FREAD, KIND_EREAD, KIND_JUMP
   } kind_type;

   localparam logic [1:0] CSR_SIGNATURE = 2'd0;
   localparam logic [1:0] CSR_DEVCODE   = 2'd1;
   localparam logic [1:0] CSR_APPEND    = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] addr;
      logic [15:0] pay;
   } result_type;

   // up to eight results of one item
   typedef struct packed {
      logic [3:0]       count;
      result_type [7:0] res;
   } batch_type;
endpackage
`default_nettype wire

### rtl/core/sbce_out_queue.sv
// output queue: holds the results of one item and emits them one beat at a time
// depends on sbce_pkg
`default_nettype none
module sbce_out_queue
   import sbce_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire batch_type  batch,
   output logic            busy,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_kind,
   output logic [15:0]     rsp_mem_address,
   output logic [15:0]     rsp_payload,
   output logic            rsp_last
);
   batch_type  batch_ff;
   logic [3:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;

   // step through the stored results
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         pos_in = pos_ff + 4'd1;
         if (pos_in == batch_ff.count) valid_in = 1'b0;
      end
      if (load && batch.count != 4'd0) begin
         pos_in   = 4'd0;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      if (load) batch_ff <= batch;
   end

   // free for a new batch once the final beat leaves
   assign busy            = valid_ff && !(rsp_last && !rsp_stall);
   assign rsp_valid       = valid_ff;
   assign rsp_kind        = batch_ff.res[pos_ff[2:0]].kind;
   assign rsp_mem_address = batch_ff.res[pos_ff[2:0]].addr;
   assign rsp_payload     = batch_ff.res[pos_ff[2:0]].pay;
   assign rsp_last        = (pos_ff + 4'd1) == batch_ff.count;
endmodule
`default_nettype wire

### rtl/core/serial_bootloader_command_engine.sv
// serial bootloader command engine: parses command bytes, drives memory commands
// results of an item are registered and appear in the cycle after the beat is taken;
// one item per cycle when an item has at most one result and the output does not
// stall, else requests stall until the last result of the item leaves the output queue
// reset: synchronous, clears parser to idle, registers to defaults, page buffer valid bits to zero
// page buffer is a 64-word memory kept zero by per-word valid bits after reset
`default_nettype none
module serial_bootloader_command_engine
   import sbce_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [15:0] req_read_data,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [15:0]      rsp_mem_address,
   output logic [15:0]      rsp_payload,
   output logic             rsp_last
);
   logic [23:0] sig_ff;
   logic [7:0]  dev_ff;
   logic [15:0] app_end_ff;

   parse_state_type st_ff, st_in;
   logic [15:0] wa_ff, wa_in, bc_ff, bc_in, pi_ff, pi_in, ea_ff, ea_in;
   logic [7:0]  hb_ff, hb_in;
   logic        ee_ff, ee_in;

   // page buffer memory with valid bits
   logic [15:0]         buf_mem [BufWords];
   logic [BufWords-1:0] bvalid_ff;
   logic [15:0]         rd_ff;
   logic                rd_ok_ff;
   logic [BufAw-1:0]    rd_addr;
   logic                wr_en;
   logic [BufAw-1:0]    wr_addr;
   logic [15:0]         wr_data;

   logic      busy, take, load;
   batch_type b;
   logic [15:0] fillw;

   assign req_stall = busy;
   assign take      = req_valid && !busy;
   assign load      = take;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff <= 24'd1987335; dev_ff <= 8'd118; app_end_ff <= 16'd7167;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SIGNATURE: sig_ff <= csr_data;
            CSR_DEVCODE:   dev_ff <= csr_data[7:0];
            CSR_APPEND:    app_end_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // fill word read: prefetched for next fill index; written word forwarded
   assign fillw = (pi_ff < 16'(BufWords) && rd_ok_ff) ? rd_ff : 16'd0;

   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[wr_addr] <= wr_data;
      rd_ff <= (wr_en && wr_addr == rd_addr) ? wr_data : buf_mem[rd_addr];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= '0; rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en) bvalid_ff[wr_addr] <= 1'b1;
         rd_ok_ff <= bvalid_ff[rd_addr] || (wr_en && wr_addr == rd_addr);
      end
   end

   function automatic result_type mk(input kind_type k, input logic [15:0] a,
                                     input logic [15:0] p);
      result_type r;
      r.kind = k; r.addr = a; r.pay = p;
      return r;
   endfunction

   // parser
   always_comb begin
      logic       wait_ack;
      logic [16:0] nxt;
      logic [15:0] cnt;
      logic [15:0] half;
      logic [15:0] pin;
      st_in = st_ff; wa_in = wa_ff; bc_in = bc_ff; pi_in = pi_ff;
      ea_in = ea_ff; hb_in = hb_ff; ee_in = ee_ff;
      b = '0;
      wr_en = 1'b0; wr_addr = pi_ff[BufAw-1:0];
      wr_data = {hb_ff, req_rx_byte};
      nxt = 17'(ea_ff) + 17'(FlashPageBytes);
      cnt = {hb_ff, req_rx_byte};
      half = bc_ff >> 1;
      pin = pi_ff + 16'd1;
      wait_ack = st_ff == ST_ERASE_ACK || st_ff == ST_B_FILL_ACK || st_ff == ST_B_WR_ACK
              || st_ff == ST_B_EACK || st_ff == ST_G_FACK || st_ff == ST_G_EACK;
      if (take && req_opcode == wait_ack) begin
         unique case (st_ff)
            ST_IDLE: begin
               unique case (req_rx_byte)
                  "P", "L": begin b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h0d); end
                  "a": begin b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h59); end
                  "A": st_in = ST_A_HI;
                  "e": begin
                     ea_in = '0; st_in = ST_ERASE_ACK;
                     b.count = 4'd1; b.res[0] = mk(KIND_ERASE, 16'd0, 16'd0);
                  end
                  "T", "x", "y": st_in = ST_SKIP;
                  "s": begin
                     b.count = 4'd3;
                     b.res[0] = mk(KIND_TX, 16'd0, {8'd0, sig_ff[23:16]});
                     b.res[1] = mk(KIND_TX, 16'd0, {8'd0, sig_ff[15:8]});
                     b.res[2] = mk(KIND_TX, 16'd0, {8'd0, sig_ff[7:0]});
                  end
                  "t": begin
                     b.count = 4'd2;
                     b.res[0] = mk(KIND_TX, 16'd0, {8'd0, dev_ff});
                     b.res[1] = mk(KIND_TX, 16'd0, 16'd0);
                  end
                  "S": begin
                     b.count = 4'd7;
                     b.res[0] = mk(KIND_TX, 16'd0, 16'h46);
                     b.res[1] = mk(KIND_TX, 16'd0, 16'h4e);
                     b.res[2] = mk(KIND_TX, 16'd0, 16'h4f);
                     b.res[3] = mk(KIND_TX, 16'd0, 16'h52);
                     b.res[4] = mk(KIND_TX, 16'd0, 16'h44);
                     b.res[5] = mk(KIND_TX, 16'd0, 16'h21);
                     b.res[6] = mk(KIND_TX, 16'd0, 16'h31);
                  end
                  "V": begin
                     b.count = 4'd2;
                     b.res[0] = mk(KIND_TX, 16'd0, 16'h32);
                     b.res[1] = mk(KIND_TX, 16'd0, 16'h33);
                  end
                  "p": begin b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h53); end
                  "E": begin b.count = 4'd1; b.res[0] = mk(KIND_JUMP, 16'd0, 16'd0); end
                  "b": begin
                     b.count = 4'd3;
                     b.res[0] = mk(KIND_TX, 16'd0, 16'h59);
                     b.res[1] = mk(KIND_TX, 16'd0, {8'd0, 8'(BufferBytes >> 8)});
                     b.res[2] = mk(KIND_TX, 16'd0, {8'd0, 8'(BufferBytes)});
                  end
                  "B": st_in = ST_B_CHI;
                  "g": st_in = ST_G_CHI;
                  default: begin b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h3f); end
               endcase
            end
            ST_A_HI: begin hb_in = req_rx_byte; st_in = ST_A_LO; end
            ST_A_LO: begin
               wa_in = cnt; st_in = ST_IDLE;
               b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h0d);
            end
            ST_SKIP: begin
               st_in = ST_IDLE; b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h0d);
            end
            ST_ERASE_ACK: begin
               b.count = 4'd1;
               if (nxt <= 17'(app_end_ff)) begin
                  ea_in = nxt[15:0]; b.res[0] = mk(KIND_ERASE, nxt[15:0], 16'd0);
               end else begin
                  st_in = ST_IDLE; b.res[0] = mk(KIND_TX, 16'd0, 16'h0d);
               end
            end
            ST_B_CHI: begin hb_in = req_rx_byte; st_in = ST_B_CLO; end
            ST_G_CHI: begin hb_in = req_rx_byte; st_in = ST_G_CLO; end
            ST_B_CLO: begin
               bc_in = cnt;
               if (cnt > 16'(BufferBytes)) begin
                  st_in = ST_IDLE; b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h3f);
               end else st_in = ST_B_TYPE;
            end
            ST_G_CLO: begin bc_in = cnt; st_in = ST_G_TYPE; end
            ST_B_TYPE: begin
               pi_in = '0;
               if (req_rx_byte == "F") begin
                  ee_in = 1'b0;
                  if (half == 16'd0) begin
                     st_in = ST_B_FILL_ACK; b.count = 4'd1;
                     b.res[0] = mk(KIND_FILL, 16'(wa_ff << 1),
                                   bvalid_ff[0] ? rd_ff : 16'd0);
                  end else st_in = ST_B_WHI;
               end else if (req_rx_byte == "E") begin
                  ee_in = 1'b1;
                  if (bc_ff == 16'd0) begin
                     st_in = ST_IDLE; b.count = 4'd1;
                     b.res[0] = mk(KIND_TX, 16'd0, 16'h0d);
                  end else st_in = ST_B_EDATA;
               end else begin
                  st_in = ST_IDLE; b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h3f);
               end
            end
            ST_B_WHI: begin hb_in = req_rx_byte; st_in = ST_B_WLO; end
            ST_B_WLO: begin
               wr_en = pi_ff < 16'(BufWords);
               if (pin >= half) begin
                  pi_in = '0; st_in = ST_B_FILL_ACK; b.count = 4'd1;
                  // word 0 may be the one just written
                  b.res[0] = mk(KIND_FILL, 16'(wa_ff << 1),
                                (pi_ff == 16'd0) ? wr_data
                                : (bvalid_ff[0] ? rd_ff : 16'd0));
               end else begin
                  pi_in = pin; st_in = ST_B_WHI;
               end
            end
            ST_B_FILL_ACK: begin
               pi_in = pin; b.count = 4'd1;
               if (pin < 16'(FillWords))
                  b.res[0] = mk(KIND_FILL, 16'((wa_ff + pin) << 1), fillw);
               else begin
                  st_in = ST_B_WR_ACK;
                  b.res[0] = mk(KIND_PWRITE, 16'(wa_ff << 1), 16'd0);
               end
            end
            ST_B_WR_ACK: begin
               wa_in = wa_ff + half; st_in = ST_IDLE;
               b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h0d);
            end
            ST_B_EDATA: begin
               st_in = ST_B_EACK; b.count = 4'd1;
               b.res[0] = mk(KIND_EWRITE, wa_ff, {8'd0, req_rx_byte});
            end
            ST_B_EACK: begin
               wa_in = wa_ff + 16'd1; pi_in = pin;
               if (pin < bc_ff) st_in = ST_B_EDATA;
               else begin
                  st_in = ST_IDLE; b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h0d);
               end
            end
            ST_G_TYPE: begin
               pi_in = '0;
               if (req_rx_byte == "F") begin
                  ee_in = 1'b0;
                  if (bc_ff == 16'd0) st_in = ST_IDLE;
                  else begin
                     st_in = ST_G_FACK; b.count = 4'd1;
                     b.res[0] = mk(KIND_FREAD, 16'(wa_ff << 1), 16'd0);
                  end
               end else if (req_rx_byte == "E") begin
                  ee_in = 1'b1;
                  if (bc_ff == 16'd0) st_in = ST_IDLE;
                  else begin
                     st_in = ST_G_EACK; b.count = 4'd1;
                     b.res[0] = mk(KIND_EREAD, wa_ff, 16'd0);
                  end
               end else begin
                  st_in = ST_IDLE; b.count = 4'd1; b.res[0] = mk(KIND_TX, 16'd0, 16'h3f);
               end
            end
            ST_G_FACK: begin
               wa_in = wa_ff + 16'd1; pi_in = pin; b.count = 4'd2;
               b.res[0] = mk(KIND_TX, 16'd0, {8'd0, req_read_data[15:8]});
               b.res[1] = mk(KIND_TX, 16'd0, {8'd0, req_read_data[7:0]});
               if (17'(pin) < ((17'(bc_ff) + 17'd1) >> 1)) begin
                  b.count = 4'd3; b.res[2] = mk(KIND_FREAD, 16'(wa_in << 1), 16'd0);
               end else st_in = ST_IDLE;
            end
            ST_G_EACK: begin
               wa_in = wa_ff + 16'd1; pi_in = pin; b.count = 4'd1;
               b.res[0] = mk(KIND_TX, 16'd0, {8'd0, req_read_data[7:0]});
               if (pin < bc_ff) begin
                  b.count = 4'd2; b.res[1] = mk(KIND_EREAD, wa_in, 16'd0);
               end else st_in = ST_IDLE;
            end
            default: st_in = ST_IDLE;
         endcase
      end
      // prefetch the fill word for the next fill index
      rd_addr = (st_in == ST_B_FILL_ACK) ? BufAw'(pi_in + 16'd1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; wa_ff <= '0; bc_ff <= '0; pi_ff <= '0;
         ea_ff <= '0; hb_ff <= '0; ee_ff <= 1'b0;
      end else begin
         st_ff <= st_in; wa_ff <= wa_in; bc_ff <= bc_in; pi_ff <= pi_in;
         ea_ff <= ea_in; hb_ff <= hb_in; ee_ff <= ee_in;
      end
   end

   sbce_out_queue u_queue (
      .clock, .reset, .load, .batch(b), .busy,
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_mem_address, .rsp_payload, .rsp_last
   );
endmodule
`default_nettype wire
